### rtl/bidset_pkg.sv
// Shared types and constants for the bounded identifier set table.
// No dependencies; used by bidset_ctrl, bidset_dp and bounded_id_set_table.
package bidset_pkg;

  localparam int CMD_W   = 2;
  localparam int ID_W    = 32;
  localparam int COUNT_W = 6;

  // Reserved identifiers, refused by add and remove
  localparam logic [ID_W-1:0] ID_RSVD_ZERO = '0;
  localparam logic [ID_W-1:0] ID_RSVD_ONES = '1;

  // Command codes; the fourth code is refused
  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_SHIFT,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture request, restart walk
    logic scan;        // advance search walk
    logic shift_init;  // point walk just above the matching slot
    logic shift;       // advance walk, move each entry down one slot
    logic shift_end;   // drop count, clear the freed slot
    logic append;      // write identifier at the top, bump count
    logic set_ok;      // capture the accepted flag
    logic ok_val;
  } dp_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             reserved;
    logic             found;
    logic             full;
    logic             hit;
    logic             walk_end;
  } dp_stat_t;

endpackage

### rtl/bounded_id_set_table.sv
// Top level of the bounded identifier set table: controller plus datapath.
// Depends on bidset_pkg, bidset_ctrl and bidset_dp.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-------------------------------------------------
//  request  | start / busy       | in_command, in_node_id
//  result   | out_valid (strobe) | out_accepted, out_was_present, out_entry_count
//
// The search stops at the slot that hits, or walks every stored entry when it
// misses. A remove that hits slot s then compacts the entries above s before the
// result. The block is idle in the cycle after the result and takes the next
// start at the end of that cycle. The single read port of the entry memory means
// that search and compaction visit one entry per cycle.
// Reset (rst_n low, synchronous) empties the table through the entry count.
// The result is shown for exactly one cycle; the receiver cannot stall it.
module bounded_id_set_table #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [bidset_pkg::CMD_W-1:0]    in_command,
  input  logic [bidset_pkg::ID_W-1:0]     in_node_id,
  output logic                            out_valid,
  output logic                            out_accepted,
  output logic                            out_was_present,
  output logic [bidset_pkg::COUNT_W-1:0]  out_entry_count
);

  bidset_pkg::dp_ctrl_t ctrl;
  bidset_pkg::dp_stat_t stat;

  // Sequence each request
  bidset_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .ctrl      (ctrl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Hold entries and results
  bidset_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_command),
    .in_node_id      (in_node_id),
    .ctrl            (ctrl),
    .stat            (stat),
    .out_accepted    (out_accepted),
    .out_was_present (out_was_present),
    .out_entry_count (out_entry_count)
  );

endmodule

### rtl/bidset_dp.sv
// Datapath: request registers, entry memory, walk pointer, count and result flags.
// Depends on bidset_pkg; driven by bidset_ctrl through dp_ctrl_t.
module bidset_dp #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [bidset_pkg::CMD_W-1:0]    in_command,
  input  logic [bidset_pkg::ID_W-1:0]     in_node_id,
  input  bidset_pkg::dp_ctrl_t            ctrl,
  output bidset_pkg::dp_stat_t            stat,
  output logic                            out_accepted,
  output logic                            out_was_present,
  output logic [bidset_pkg::COUNT_W-1:0]  out_entry_count
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [bidset_pkg::ID_W-1:0]  mem [MAX_ENTRIES];

  logic [bidset_pkg::CMD_W-1:0] cmd_r;
  logic [bidset_pkg::ID_W-1:0]  id_r;
  logic [CW-1:0]                count_r, count_nxt;
  logic [CW-1:0]                ptr_r, ptr_nxt;
  logic [CW-1:0]                rd_idx_r;
  logic                         rd_vld_r, rd_vld_nxt;
  logic [bidset_pkg::ID_W-1:0]  rd_data_r;
  logic                         found_r, found_nxt;
  logic [CW-1:0]                slot_r;
  logic                         ok_r;

  logic                         rd_go;
  logic                         hit;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [bidset_pkg::ID_W-1:0]  wr_data;
  logic [CW-1:0]                down_idx;
  logic [CW-1:0]                last_idx;

  // Walk status
  assign rd_go    = (ctrl.scan || ctrl.shift) && (ptr_r < count_r);
  assign hit      = rd_vld_r && (rd_data_r == id_r);
  assign down_idx = rd_idx_r - CW'(1);
  assign last_idx = count_r - CW'(1);

  assign stat.cmd      = cmd_r;
  assign stat.reserved = (id_r == bidset_pkg::ID_RSVD_ZERO) ||
                         (id_r == bidset_pkg::ID_RSVD_ONES);
  assign stat.found    = found_r;
  assign stat.full     = (count_r == CW'(MAX_ENTRIES));
  assign stat.hit      = hit;
  assign stat.walk_end = (ptr_r >= count_r) && !rd_vld_r;

  // Select the single memory write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = id_r;
    if (ctrl.append) begin
      wr_en = 1'b1;
    end else if (ctrl.shift && rd_vld_r) begin
      wr_en   = 1'b1;
      wr_addr = down_idx[AW-1:0];
      wr_data = rd_data_r;
    end else if (ctrl.shift_end) begin
      wr_en   = 1'b1;
      wr_addr = last_idx[AW-1:0];
      wr_data = '0;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      rd_data_r <= mem[ptr_r[AW-1:0]];
      rd_idx_r  <= ptr_r;
    end
  end

  // Next walk and control values
  always_comb begin
    ptr_nxt    = ptr_r;
    rd_vld_nxt = rd_vld_r;
    found_nxt  = found_r;
    count_nxt  = count_r;
    if (ctrl.load) begin
      ptr_nxt    = '0;
      rd_vld_nxt = 1'b0;
      found_nxt  = 1'b0;
    end else if (ctrl.shift_init) begin
      ptr_nxt    = slot_r + CW'(1);
      rd_vld_nxt = 1'b0;
    end else if (ctrl.scan || ctrl.shift) begin
      rd_vld_nxt = rd_go;
      if (rd_go) begin
        ptr_nxt = ptr_r + CW'(1);
      end
      if (ctrl.scan && hit) begin
        found_nxt = 1'b1;
      end
    end
    if (ctrl.append) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.shift_end) begin
      count_nxt = last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      ptr_r    <= ptr_nxt;
      rd_vld_r <= rd_vld_nxt;
      found_r  <= found_nxt;
    end
  end

  // Request payload and result flags
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_command;
      id_r  <= in_node_id;
    end
    if (ctrl.scan && hit) begin
      slot_r <= rd_idx_r;
    end
    if (ctrl.set_ok) begin
      ok_r <= ctrl.ok_val;
    end
  end

  assign out_accepted    = ok_r;
  assign out_was_present = found_r;
  assign out_entry_count = bidset_pkg::COUNT_W'(count_r);

  // Count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count above table size");

  // Append only with room left
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.append |-> !stat.full)
    else $error("append into full table");

  // Count changes only through append or remove
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(ctrl.append) && !$past(ctrl.shift_end) |-> $stable(count_r))
    else $error("entry count changed without add or remove");

endmodule

### rtl/bidset_ctrl.sv
// Controller: sequences search, add, remove-with-compaction and result strobe.
// Depends on bidset_pkg; commands bidset_dp through dp_ctrl_t.
module bidset_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  bidset_pkg::dp_stat_t stat,
  output bidset_pkg::dp_ctrl_t ctrl,
  output logic                 busy,
  output logic                 out_valid
);

  bidset_pkg::state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bidset_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    out_valid = 1'b0;
    case (state_r)
      bidset_pkg::ST_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          state_nxt = bidset_pkg::ST_SCAN;
        end
      end
      bidset_pkg::ST_SCAN: begin
        ctrl.scan = 1'b1;
        if (stat.hit || stat.walk_end) begin
          state_nxt = bidset_pkg::ST_EXEC;
        end
      end
      bidset_pkg::ST_EXEC: begin
        ctrl.set_ok = 1'b1;
        state_nxt   = bidset_pkg::ST_DONE;
        case (stat.cmd)
          bidset_pkg::CMD_LOOKUP: begin
            ctrl.ok_val = 1'b1;
          end
          bidset_pkg::CMD_ADD: begin
            if (!stat.reserved) begin
              if (stat.found) begin
                ctrl.ok_val = 1'b1;
              end else if (!stat.full) begin
                ctrl.ok_val = 1'b1;
                ctrl.append = 1'b1;
              end
            end
          end
          bidset_pkg::CMD_REMOVE: begin
            if (!stat.reserved) begin
              ctrl.ok_val = 1'b1;
              if (stat.found) begin
                ctrl.shift_init = 1'b1;
                state_nxt       = bidset_pkg::ST_SHIFT;
              end
            end
          end
          default: begin
            ctrl.ok_val = 1'b0;
          end
        endcase
      end
      bidset_pkg::ST_SHIFT: begin
        if (stat.walk_end) begin
          ctrl.shift_end = 1'b1;
          state_nxt      = bidset_pkg::ST_DONE;
        end else begin
          ctrl.shift = 1'b1;
        end
      end
      bidset_pkg::ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = bidset_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bidset_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != bidset_pkg::ST_IDLE);

  // Result strobe lasts one cycle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held over two cycles");

  // Accepted request makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

endmodule
